// File: sv/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int CalCount = 6;
   localparam int CsrIdxW  = 3;
   localparam int RawW     = 24;
   localparam int CalW     = 16;
   localparam int TempW    = 19;
   localparam int PresW    = 32;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;

   localparam logic [CsrIdxW-1:0] CSR_C1 = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_C2 = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_C3 = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_C4 = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_C5 = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_C6 = 3'd5;

   typedef enum logic [1:0] {
      BAND_HIGH    = 2'd0,
      BAND_LOW     = 2'd1,
      BAND_VERYLOW = 2'd2
   } band_type;

   // Beat handed from the front end to the back end.
   typedef struct packed {
      logic signed [25:0] dt;
      logic signed [31:0] temp;
      logic signed [63:0] sens;
      logic signed [63:0] off;
      logic [RawW-1:0]    d1;
      band_type           band;
   } work_type;

   typedef struct packed {
      logic [CalW-1:0] c1;
      logic [CalW-1:0] c2;
      logic [CalW-1:0] c3;
      logic [CalW-1:0] c4;
      logic [CalW-1:0] c5;
      logic [CalW-1:0] c6;
   } cal_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQ   = 6'b000010,
      ST_CORR = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_PRES = 6'b100000
   } back_state_type;

endpackage
`default_nettype wire

// File: sv/ptc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_front
// Front end: first-order dT, TEMP, SENS, OFF and band selection, pipelined.
// ----------------------------------------------------------------------------
module ptc_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [ptc_pkg::RawW-1:0] d1,
   input  wire logic [ptc_pkg::RawW-1:0] d2,
   input  wire ptc_pkg::cal_type         cal,
   output logic                          out_valid,
   output ptc_pkg::work_type             out_work
);
   import ptc_pkg::*;

   logic               v1_ff, v2_ff, v3_ff;
   logic               v1_in, v2_in, v3_in;
   logic signed [25:0] dt1_ff, dt2_ff, dt3_ff;
   logic [RawW-1:0]    d1a_ff, d1b_ff, d1c_ff;
   logic signed [42:0] p6_ff, p3_ff, p4_ff;
   logic signed [31:0] temp3_ff;
   logic signed [63:0] sens3_ff, off3_ff;
   logic signed [42:0] p6, p3, p4;
   logic signed [42:0] q6, q3, q4;
   logic signed [31:0] temp_c;
   logic signed [63:0] sens_c, off_c;

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   assign p6 = dt1_ff * $signed({1'b0, cal.c6});
   assign p3 = dt1_ff * $signed({1'b0, cal.c3});
   assign p4 = dt1_ff * $signed({1'b0, cal.c4});

   // truncate toward zero: bias negatives before the shift
   assign q6 = (p6_ff + (p6_ff[42] ? 43'sd8388607 : 43'sd0)) >>> 23;
   assign q3 = (p3_ff + (p3_ff[42] ? 43'sd255 : 43'sd0)) >>> 8;
   assign q4 = (p4_ff + (p4_ff[42] ? 43'sd127 : 43'sd0)) >>> 7;

   assign temp_c = 32'sd2000 + 32'(q6);
   assign sens_c = $signed({33'd0, cal.c1, 15'd0} >> 0) + 64'(q3);
   assign off_c  = $signed({32'd0, cal.c2, 16'd0} >> 0) + 64'(q4);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      dt1_ff   <= $signed({2'b00, d2}) - $signed({2'b00, cal.c5, 8'd0});
      d1a_ff   <= d1;
      dt2_ff   <= dt1_ff;
      d1b_ff   <= d1a_ff;
      p6_ff    <= p6;
      p3_ff    <= p3;
      p4_ff    <= p4;
      dt3_ff   <= dt2_ff;
      d1c_ff   <= d1b_ff;
      temp3_ff <= temp_c;
      sens3_ff <= sens_c;
      off3_ff  <= off_c;
   end

   assign out_valid     = v3_ff;
   assign out_work.dt   = dt3_ff;
   assign out_work.temp = temp3_ff;
   assign out_work.sens = sens3_ff;
   assign out_work.off  = off3_ff;
   assign out_work.d1   = d1c_ff;
   assign out_work.band = (temp3_ff < -32'sd1500) ? BAND_VERYLOW :
                          (temp3_ff < 32'sd2000)  ? BAND_LOW : BAND_HIGH;
endmodule
`default_nettype wire

// File: sv/ptc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module ptc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ptc_pkg::work_type push_data,
   input  wire logic              pop,
   output logic                   not_empty,
   output ptc_pkg::work_type      head
);
   import ptc_pkg::*;

   work_type              mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]  wr_ff, rd_ff, wr_in, rd_in;
   logic [QueuePtrW:0]    cnt_ff, cnt_in;

   assign wr_in  = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
endmodule
`default_nettype wire

// File: sv/ptc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_back
// Back end: second-order correction and final pressure, multi-cycle sequence.
// ----------------------------------------------------------------------------
module ptc_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire ptc_pkg::work_type        in_work,
   output logic                          in_pop,
   output logic                          rsp_valid,
   output logic [ptc_pkg::TempW-1:0]     rsp_temp,
   output logic [ptc_pkg::PresW-1:0]     rsp_pres
);
   import ptc_pkg::*;

   back_state_type     st_ff, st_in;
   work_type           w_ff;
   logic signed [51:0] dt2_ff;
   logic signed [63:0] dl2_ff, e2_ff;
   logic signed [TempW-1:0] temp_ff;
   logic signed [37:0] sensx_ff;
   logic signed [63:0] offx_ff;
   logic signed [31:0] dl, e;
   logic signed [51:0] ti;
   logic signed [63:0] offi, sensi;
   logic signed [24:0] d1s;
   logic signed [62:0] prod, prod_ff;
   logic signed [63:0] a, a_ff, b, pq;
   logic               rv_ff;
   logic [TempW-1:0]   rt_ff;
   logic [PresW-1:0]   rp_ff;

   assign in_pop = (st_ff == ST_IDLE) && in_valid;
   assign dl = w_ff.temp - 32'sd2000;
   assign e  = w_ff.temp + 32'sd1500;

   always_comb begin
      ti    = '0;
      offi  = '0;
      sensi = '0;
      case (w_ff.band)
         BAND_HIGH: begin
            ti   = dt2_ff >>> 36;
            offi = dl2_ff >>> 4;
         end
         BAND_LOW: begin
            ti    = (52'sd3 * dt2_ff) >>> 33;
            offi  = (64'sd3 * dl2_ff) >>> 1;
            sensi = (64'sd5 * dl2_ff) >>> 3;
         end
         BAND_VERYLOW: begin
            ti    = (52'sd3 * dt2_ff) >>> 33;
            offi  = ((64'sd3 * dl2_ff) >>> 1) + 64'sd7 * e2_ff;
            sensi = ((64'sd5 * dl2_ff) >>> 3) + 64'sd4 * e2_ff;
         end
         default: ;
      endcase
   end

   assign d1s  = $signed({1'b0, w_ff.d1});
   assign prod = 63'(d1s) * 63'(sensx_ff);
   assign a    = 64'((prod_ff + (prod_ff[62] ? 63'sd2097151 : 63'sd0)) >>> 21) - offx_ff;
   assign b    = a_ff + (a_ff[63] ? 64'sd8191 : 64'sd0);
   assign pq   = b >>> 13;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (in_valid) st_in = ST_SQ;
         ST_SQ:   st_in = ST_CORR;
         ST_CORR: st_in = ST_MUL;
         ST_MUL:  st_in = ST_DIV;
         ST_DIV:  st_in = ST_PRES;
         ST_PRES: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= (st_ff == ST_PRES);
      end
      if (in_pop) w_ff <= in_work;
      if (st_ff == ST_SQ) begin
         dt2_ff <= w_ff.dt * w_ff.dt;
         dl2_ff <= 64'(dl) * 64'(dl);
         e2_ff  <= 64'(e) * 64'(e);
      end
      if (st_ff == ST_CORR) begin
         temp_ff  <= TempW'(w_ff.temp - 32'(ti));
         sensx_ff <= 38'(w_ff.sens - sensi);
         offx_ff  <= w_ff.off - offi;
      end
      if (st_ff == ST_MUL) prod_ff <= prod;
      if (st_ff == ST_DIV) a_ff <= a;
      if (st_ff == ST_PRES) begin
         rt_ff <= temp_ff;
         if (pq > 64'sd2147483647)       rp_ff <= 32'h7FFF_FFFF;
         else if (pq < -64'sd2147483648) rp_ff <= 32'h8000_0000;
         else                            rp_ff <= pq[31:0];
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_temp  = rt_ff;
   assign rsp_pres  = rp_ff;
endmodule
`default_nettype wire

// File: sv/pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temp_compensation_core
// Second-order temperature-compensated pressure conversion.
// ----------------------------------------------------------------------------
// A start with busy low is taken; its one result is strobed on rsp_valid
// for a single cycle and must be captured then, as the receiver cannot
// stall. The front pipeline takes a beat every cycle while busy is low; the
// back sequencer works each beat through pop, square, correct, multiply,
// divide and saturate and pops no new beat until idle, so busy rises while
// two beats sit in the front pipeline and queue. The user is to write the
// calibration registers through csr_ only while idle; nothing enforces it.
module pressure_temp_compensation_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ptc_pkg::RawW-1:0]      req_raw_pressure,
   input  wire logic [ptc_pkg::RawW-1:0]      req_raw_temperature,
   output logic                               rsp_valid,
   output logic signed [ptc_pkg::TempW-1:0]   rsp_temperature_out,
   output logic signed [ptc_pkg::PresW-1:0]   rsp_pressure_out,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ptc_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [ptc_pkg::CalW-1:0]      csr_data
);
   import ptc_pkg::*;

   cal_type  cal_ff;
   logic     acc, fv, qne, pop;
   work_type fw, qh;
   logic [2:0] inflight_ff, inflight_in;

   assign csr_ready = 1'b1;
   // front stages plus queue never hold more beats than the queue depth
   assign busy = (inflight_ff >= 3'(QueueDepth));
   assign acc  = start && !busy;
   assign inflight_in = inflight_ff + 3'(acc) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff      <= '0;
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_C1:  cal_ff.c1 <= csr_data;
               CSR_C2:  cal_ff.c2 <= csr_data;
               CSR_C3:  cal_ff.c3 <= csr_data;
               CSR_C4:  cal_ff.c4 <= csr_data;
               CSR_C5:  cal_ff.c5 <= csr_data;
               CSR_C6:  cal_ff.c6 <= csr_data;
               default: ;
            endcase
         end
      end
   end

   ptc_front u_front (
      .clock(clock), .reset(reset), .in_valid(acc),
      .d1(req_raw_pressure), .d2(req_raw_temperature), .cal(cal_ff),
      .out_valid(fv), .out_work(fw)
   );

   ptc_queue u_queue (
      .clock(clock), .reset(reset), .push(fv), .push_data(fw),
      .pop(pop), .not_empty(qne), .head(qh)
   );

   ptc_back u_back (
      .clock(clock), .reset(reset), .in_valid(qne), .in_work(qh),
      .in_pop(pop), .rsp_valid(rsp_valid), .rsp_temp(rsp_temperature_out),
      .rsp_pres(rsp_pressure_out)
   );
endmodule
`default_nettype wire
